>>> hdl/tsct_pkg.sv
package tsct_pkg;

  // Field and register widths
  localparam int TIME_W    = 32;
  localparam int DIST_W    = 20;
  localparam int SPD_W     = 16;
  localparam int TURN_W    = 15;
  localparam int DIR_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;

  // Datapath widths: multiplier operands, product, divisor, signed time differences
  localparam int MA_W      = 38;
  localparam int MB_W      = 20;
  localparam int P_W       = MA_W + MB_W;
  localparam int DVS_W     = 34;
  localparam int SW        = TIME_W + 4;
  localparam int NUM_W     = MA_W + 2;
  localparam int DIV_CNT_W = $clog2(P_W + 1);

  localparam logic [MB_W-1:0] US_PER_S = MB_W'(1000000);

  // Division by one million: 1000000 = 15625 * 2^6. The product is shifted down by six,
  // then divided by 15625 with a rounded-up reciprocal, exact for a 30-bit operand.
  // Anything wider gives a quotient above every speed limit and is clamped.
  localparam int E_SH    = 6;
  localparam int RN_W    = 30;
  localparam int RM_W    = 31;
  localparam int RP_W    = RN_W + RM_W;
  localparam int RECIP_K = 44;
  localparam int RQ_W    = RP_W - RECIP_K;
  localparam logic [RM_W-1:0] RECIP_M = RM_W'(1125899907);

  // Register reset values
  localparam logic [DIR_W-1:0]  RST_TURN_DIR  = DIR_W'(1);
  localparam logic [SPD_W-1:0]  RST_MAX_SPEED = SPD_W'(500);
  localparam logic [SPD_W-1:0]  RST_ACCEL     = SPD_W'(500);
  localparam logic [TURN_W-1:0] RST_MAX_TURN  = TURN_W'(1000);

  localparam logic [DIR_W-1:0] DIR_STRAIGHT = DIR_W'(0);

  // Reported phase codes
  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_BEFORE = 3'd0,
    CFG_CURVE_LEN   = 3'd1,
    CFG_DIST_AFTER  = 3'd2,
    CFG_TURN_DIR    = 3'd3,
    CFG_MAX_SPEED   = 3'd4,
    CFG_PATH_ACCEL  = 3'd5,
    CFG_MAX_TURN    = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MP_IDLE,
    MP_ACCEL,
    MP_CRUISE,
    MP_DECEL,
    MP_STOP
  } mphase_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_M_VME,
    OP_M_LKE,
    OP_M_VV,
    OP_M_DV,
    OP_M_SVA,
    OP_M_L1VA,
    OP_M_NUME,
    OP_SUB_TC,
    OP_SUB_OFS,
    OP_DIV_VA,
    OP_DIV_VM,
    OP_DIV_DV,
    OP_DIV_DV2,
    OP_WB_ACC,
    OP_WB_RAMP,
    OP_WB_CRU,
    OP_WB_OFS,
    OP_ELAP,
    OP_DIFF,
    OP_DIFF2,
    OP_M_SAMPLE,
    OP_DIV_SAMPLE,
    OP_WB_SAMPLE
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_S_VME,
    ST_S_DIVACC,
    ST_S_WACC,
    ST_S_LKE,
    ST_S_DIVRAMP,
    ST_S_WRAMP,
    ST_S_VV,
    ST_S_DV,
    ST_S_SVA,
    ST_S_TCSUB,
    ST_S_TCCHK,
    ST_S_TCDIV,
    ST_S_WCRU,
    ST_S_L1VA,
    ST_S_OFSSUB,
    ST_S_OFSE,
    ST_S_OFSDIV,
    ST_S_WOFS,
    ST_ELAP,
    ST_DIFF,
    ST_DIFF2,
    ST_P_MUL,
    ST_P_DIV,
    ST_P_WAIT,
    ST_EMIT0,
    ST_EMIT1
  } state_t;

  typedef struct packed {
    op_t  op;
    logic out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic    is_start;
    mphase_t mphase;
    logic    div_busy;
    logic    num_pos;
    logic    sample_div;
    logic    two_res;
  } dp_stat_t;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] time_stamp;
  } item_t;

  typedef struct packed {
    logic [SPD_W-1:0]        speed_cmd;
    logic signed [SPD_W-1:0] turn_rate_cmd;
    logic [1:0]              phase;
    logic                    done_res;
    logic                    last_result;
  } result_t;

endpackage

>>> hdl/trapezoid_speed_clothoid_turn_profile_core.sv
// Trapezoidal speed profile with a triangular turn-rate ramp over the curve. A start item
// (command 0) latches its time stamp and derives accelerate, cruise, curve-start and curve-ramp
// times; it gives no result and makes up to four passes through the bit-serial divider (three
// when the cruise numerator is not positive). A time sample (command 1) gives one or two result
// beats. During a turn ramp the sample is divided by the ramp time in that divider; an
// accelerate sample, or a decelerate sample past the end of cruise, divides by one million
// through a reciprocal multiply; any other sample needs neither. One item is handled at a time;
// the next is taken once the last beat has left. A sample while idle or stopped is dropped.
// Configuration must be written only while idle; the core itself does not enforce this.
module trapezoid_speed_clothoid_turn_profile_core import tsct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  tsct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

>>> hdl/tsct_div.sv
module tsct_div import tsct_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [P_W-1:0]   dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [P_W-1:0]   quotient
);

  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       rem_sh;
  logic [DVS_W:0]       diff;
  logic                 take;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, quotient[P_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    take   = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= DIV_CNT_W'(P_W);
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quotient <= {quotient[P_W-2:0], take};
      cnt      <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/tsct_datapath.sv
module tsct_datapath import tsct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output result_t              result
);

  // configuration
  logic [DIST_W-1:0] dist_before, curve_len, dist_after;
  logic [DIR_W-1:0]  turn_dir;
  logic [SPD_W-1:0]  max_speed, path_accel;
  logic [TURN_W-1:0] max_turn;

  // profile state
  mphase_t                  mphase;
  logic [TIME_W-1:0]        start_time, acc_dur, cru_dur, ramp_dur;
  logic signed [TIME_W-1:0] ofs;

  // working registers
  logic                     cmd_r;
  logic [TIME_W-1:0]        ts_r, e, vv, dv;
  logic signed [SW-1:0]     dc, dd, x;
  logic [P_W-1:0]           p;
  logic signed [NUM_W-1:0]  num;
  result_t                  res0, res1;
  logic                     two_res;
  logic [RQ_W-1:0]          qr;

  logic [SPD_W-1:0]         vm, va;
  logic [DIST_W+1:0]        dist_sum;
  logic [NUM_W-1:0]         num_mag;
  logic                     num_pos;
  logic [MA_W-1:0]          ma;
  logic [MB_W-1:0]          mb;
  logic [P_W-1:0]           prod;
  logic                     div_start;
  logic [DVS_W-1:0]         divisor;
  logic                     div_busy;
  logic [P_W-1:0]           q;
  logic                     r_big;
  logic [RN_W-1:0]          rn;
  logic [RP_W-1:0]          rprod;

  logic signed [SW-1:0]     r_ext, r2_ext, x_back, acc_ext, cru_ext;
  logic                     b1, b2, dd_pos, sample_div;
  logic [TIME_W-1:0]        turn_arg;
  logic [SPD_W-1:0]         spd_acc, spd_dec, w;
  logic signed [SPD_W-1:0]  turn_val;
  logic                     fin_acc, fin_dec, cru_end;
  logic signed [TIME_W-1:0] ofs_w;
  logic                     pos_big, neg_big;

  function automatic logic [TIME_W-1:0] sat_time(input logic [P_W-1:0] v);
    logic [TIME_W-1:0] r;
    if (|v[P_W-1:TIME_W]) r = '1;
    else                  r = v[TIME_W-1:0];
    return r;
  endfunction

  // speed and acceleration limits of zero act as one
  assign vm       = (max_speed == '0) ? SPD_W'(1) : max_speed;
  assign va       = (path_accel == '0) ? SPD_W'(1) : path_accel;
  assign dist_sum = {2'b00, dist_before} + {2'b00, curve_len} + {2'b00, dist_after};
  assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign num_pos  = !num[NUM_W-1] && (num != '0);

  // turn ramp windows within cruise
  always_comb begin
    r_ext    = $signed({{(SW-TIME_W){1'b0}}, ramp_dur});
    r2_ext   = $signed({{(SW-TIME_W-1){1'b0}}, ramp_dur, 1'b0});
    acc_ext  = $signed({{(SW-TIME_W){1'b0}}, acc_dur});
    cru_ext  = $signed({{(SW-TIME_W){1'b0}}, cru_dur});
    x_back   = r2_ext - x;
    b1       = (x > 0) && (x < r_ext);
    b2       = (x > r_ext) && (x < r2_ext);
    turn_arg = b1 ? x[TIME_W-1:0] : x_back[TIME_W-1:0];
    dd_pos   = dd > 0;
    case (mphase)
      MP_ACCEL:  sample_div = 1'b1;
      MP_CRUISE: sample_div = b1 || b2;
      MP_DECEL:  sample_div = dd_pos;
      default:   sample_div = 1'b0;
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_M_VME:  begin ma = MA_W'(vm);          mb = US_PER_S;       end
      OP_M_LKE:  begin ma = MA_W'(curve_len);   mb = US_PER_S;       end
      OP_M_VV:   begin ma = MA_W'(vm);          mb = MB_W'(vm);      end
      OP_M_DV:   begin ma = MA_W'(vm);          mb = MB_W'(va);      end
      OP_M_SVA:  begin ma = MA_W'(dist_sum);    mb = MB_W'(va);      end
      OP_M_L1VA: begin ma = MA_W'(dist_before); mb = MB_W'(va);      end
      OP_M_NUME: begin ma = MA_W'(num_mag);     mb = US_PER_S;       end
      OP_M_SAMPLE: begin
        case (mphase)
          MP_ACCEL:  begin ma = MA_W'(e);            mb = MB_W'(va);       end
          MP_CRUISE: begin ma = MA_W'(turn_arg);     mb = MB_W'(max_turn); end
          MP_DECEL:  begin ma = MA_W'(dd[TIME_W-1:0]); mb = MB_W'(va);     end
          default:   begin ma = '0;                  mb = '0;              end
        endcase
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  // divide the sample product by one million: reciprocal of 15625 after a shift by six
  assign r_big = |p[P_W-1:RN_W+E_SH];
  assign rn    = p[RN_W+E_SH-1:E_SH];
  assign rprod = {{RM_W{1'b0}}, rn} * {{RN_W{1'b0}}, RECIP_M};

  // divider launch and divisor selection; a sample is divided, by the ramp time, only in cruise
  always_comb begin
    div_start = 1'b1;
    case (cmd.op)
      OP_DIV_VA:     divisor = DVS_W'(va);
      OP_DIV_VM:     divisor = DVS_W'(vm);
      OP_DIV_DV:     divisor = DVS_W'(dv);
      OP_DIV_DV2:    divisor = DVS_W'({dv, 1'b0});
      OP_DIV_SAMPLE: begin
        divisor   = DVS_W'(ramp_dur);
        div_start = (mphase == MP_CRUISE);
      end
      default: begin
        divisor   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  tsct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (p),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (q)
  );

  // result values for a sample
  always_comb begin
    spd_acc  = (qr >= RQ_W'(vm)) ? vm : qr[SPD_W-1:0];
    spd_dec  = dd_pos ? ((qr >= RQ_W'(vm)) ? '0 : vm - qr[SPD_W-1:0]) : vm;
    w        = (b1 || b2) ? q[SPD_W-1:0] : '0;
    turn_val = (turn_dir == DIR_STRAIGHT) ? '0 : (turn_dir[1] ? -$signed(w) : $signed(w));
    fin_acc  = e >= acc_dur;
    fin_dec  = dd >= acc_ext;
    cru_end  = dc >= cru_ext;
  end

  // signed curve offset, saturated
  always_comb begin
    pos_big = |q[P_W-1:TIME_W-1];
    neg_big = (|q[P_W-1:TIME_W]) || (q[TIME_W-1] && (|q[TIME_W-2:0]));
    if (num[NUM_W-1]) begin
      ofs_w = neg_big ? $signed({1'b1, {(TIME_W-1){1'b0}}}) : -$signed(q[TIME_W-1:0]);
    end else begin
      ofs_w = pos_big ? $signed({1'b0, {(TIME_W-1){1'b1}}}) : $signed(q[TIME_W-1:0]);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_before <= '0;
      curve_len   <= '0;
      dist_after  <= '0;
      turn_dir    <= RST_TURN_DIR;
      max_speed   <= RST_MAX_SPEED;
      path_accel  <= RST_ACCEL;
      max_turn    <= RST_MAX_TURN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIST_BEFORE: dist_before <= cfg_data[DIST_W-1:0];
        CFG_CURVE_LEN:   curve_len   <= cfg_data[DIST_W-1:0];
        CFG_DIST_AFTER:  dist_after  <= cfg_data[DIST_W-1:0];
        CFG_TURN_DIR:    turn_dir    <= cfg_data[DIR_W-1:0];
        CFG_MAX_SPEED:   max_speed   <= cfg_data[SPD_W-1:0];
        CFG_PATH_ACCEL:  path_accel  <= cfg_data[SPD_W-1:0];
        CFG_MAX_TURN:    max_turn    <= cfg_data[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      mphase     <= MP_IDLE;
      start_time <= '0;
      acc_dur    <= '0;
      cru_dur    <= '0;
      ramp_dur   <= '0;
      ofs        <= '0;
    end else begin
      case (cmd.op)
        OP_WB_ACC:  acc_dur  <= sat_time(q);
        OP_WB_RAMP: ramp_dur <= sat_time(q);
        OP_WB_CRU:  cru_dur  <= num_pos ? sat_time(q) : '0;
        OP_WB_OFS: begin
          ofs        <= ofs_w;
          start_time <= ts_r;
          mphase     <= MP_ACCEL;
        end
        OP_WB_SAMPLE: begin
          case (mphase)
            MP_ACCEL:  if (fin_acc) mphase <= MP_CRUISE;
            MP_CRUISE: if (cru_end) mphase <= MP_DECEL;
            MP_DECEL:  if (fin_dec) mphase <= MP_STOP;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // working registers and result beats
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r <= item.command;
        ts_r  <= item.time_stamp;
      end
      OP_M_VME, OP_M_LKE, OP_M_VV, OP_M_L1VA, OP_M_NUME, OP_M_SAMPLE: p <= prod;
      // the previous product is vm*vm, then vm*va
      OP_M_DV: begin
        p  <= prod;
        vv <= p[TIME_W-1:0];
      end
      OP_M_SVA: begin
        p  <= prod;
        dv <= p[TIME_W-1:0];
      end
      OP_SUB_TC:  num <= $signed(NUM_W'(p[MA_W-1:0])) - $signed(NUM_W'(vv));
      OP_SUB_OFS: num <= $signed(NUM_W'({p[MA_W-2:0], 1'b0})) - $signed(NUM_W'(vv));
      // quotient by one million, all ones when above any speed limit
      OP_DIV_SAMPLE: qr <= r_big ? '1 : rprod[RP_W-1:RECIP_K];
      OP_ELAP:    e   <= ts_r - start_time;
      OP_DIFF:    dc  <= $signed({{(SW-TIME_W){1'b0}}, e}) - acc_ext;
      OP_DIFF2: begin
        dd <= dc - cru_ext;
        x  <= dc - $signed({{(SW-TIME_W){ofs[TIME_W-1]}}, ofs});
      end
      OP_WB_SAMPLE: begin
        case (mphase)
          MP_ACCEL: begin
            res0    <= '{spd_acc, '0, PH_ACCEL, 1'b0, !fin_acc};
            res1    <= '{vm, '0, PH_CRUISE, 1'b0, 1'b1};
            two_res <= fin_acc;
          end
          MP_CRUISE: begin
            res0    <= '{vm, turn_val, PH_CRUISE, 1'b0, 1'b1};
            two_res <= 1'b0;
          end
          default: begin
            res0    <= '{spd_dec, '0, PH_DECEL, 1'b0, !fin_dec};
            res1    <= '{'0, '0, PH_STOP, 1'b1, 1'b1};
            two_res <= fin_dec;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign result = cmd.out_sel ? res1 : res0;

  assign stat = '{
    is_start:   !cmd_r,
    mphase:     mphase,
    div_busy:   div_busy,
    num_pos:    num_pos,
    sample_div: sample_div,
    two_res:    two_res
  };

endmodule

>>> hdl/tsct_ctrl.sv
module tsct_ctrl import tsct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  output logic     result_valid,
  input  logic     result_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sequencing of the datapath
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_sel  = 1'b0;
    item_stall   = 1'b1;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.is_start) begin
          state_next = ST_S_VME;
        end else if (stat.mphase == MP_ACCEL || stat.mphase == MP_CRUISE ||
                     stat.mphase == MP_DECEL) begin
          state_next = ST_ELAP;
        end else begin
          state_next = ST_IDLE;
        end
      end

      // start: accelerate time
      ST_S_VME:    begin cmd.op = OP_M_VME;  state_next = ST_S_DIVACC; end
      ST_S_DIVACC: begin cmd.op = OP_DIV_VA; state_next = ST_S_WACC;   end
      ST_S_WACC: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_WB_ACC;
          state_next = ST_S_LKE;
        end
      end
      // start: curve ramp time
      ST_S_LKE:     begin cmd.op = OP_M_LKE;  state_next = ST_S_DIVRAMP; end
      ST_S_DIVRAMP: begin cmd.op = OP_DIV_VM; state_next = ST_S_WRAMP;   end
      ST_S_WRAMP: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_WB_RAMP;
          state_next = ST_S_VV;
        end
      end
      // start: cruise time
      ST_S_VV:    begin cmd.op = OP_M_VV;   state_next = ST_S_DV;    end
      ST_S_DV:    begin cmd.op = OP_M_DV;   state_next = ST_S_SVA;   end
      ST_S_SVA:   begin cmd.op = OP_M_SVA;  state_next = ST_S_TCSUB; end
      ST_S_TCSUB: begin cmd.op = OP_SUB_TC; state_next = ST_S_TCCHK; end
      ST_S_TCCHK: begin
        if (stat.num_pos) begin
          cmd.op     = OP_M_NUME;
          state_next = ST_S_TCDIV;
        end else begin
          cmd.op     = OP_WB_CRU;
          state_next = ST_S_L1VA;
        end
      end
      ST_S_TCDIV: begin cmd.op = OP_DIV_DV; state_next = ST_S_WCRU; end
      ST_S_WCRU: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_WB_CRU;
          state_next = ST_S_L1VA;
        end
      end
      // start: curve start offset
      ST_S_L1VA:   begin cmd.op = OP_M_L1VA;  state_next = ST_S_OFSSUB; end
      ST_S_OFSSUB: begin cmd.op = OP_SUB_OFS; state_next = ST_S_OFSE;   end
      ST_S_OFSE:   begin cmd.op = OP_M_NUME;  state_next = ST_S_OFSDIV; end
      ST_S_OFSDIV: begin cmd.op = OP_DIV_DV2; state_next = ST_S_WOFS;   end
      ST_S_WOFS: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_WB_OFS;
          state_next = ST_IDLE;
        end
      end

      // time sample
      ST_ELAP:  begin cmd.op = OP_ELAP;  state_next = ST_DIFF;  end
      ST_DIFF:  begin cmd.op = OP_DIFF;  state_next = ST_DIFF2; end
      ST_DIFF2: begin cmd.op = OP_DIFF2; state_next = ST_P_MUL; end
      ST_P_MUL: begin
        if (stat.sample_div) begin
          cmd.op     = OP_M_SAMPLE;
          state_next = ST_P_DIV;
        end else begin
          cmd.op     = OP_WB_SAMPLE;
          state_next = ST_EMIT0;
        end
      end
      ST_P_DIV: begin cmd.op = OP_DIV_SAMPLE; state_next = ST_P_WAIT; end
      ST_P_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = OP_WB_SAMPLE;
          state_next = ST_EMIT0;
        end
      end

      // result beats
      ST_EMIT0: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          state_next = stat.two_res ? ST_EMIT1 : ST_IDLE;
        end
      end
      ST_EMIT1: begin
        result_valid = 1'b1;
        cmd.out_sel  = 1'b1;
        if (!result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> sim/tsct_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each command beat
// of the profile and compares it with what the core sends out.
module tsct_checker import tsct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam longint MICRO   = 1000000;
  localparam longint T_UMAX  = 64'hFFFF_FFFF;
  localparam longint T_SMAX  = 64'h7FFF_FFFF;

  // Register copy
  longint l1_mm, lk_mm, l2_mm, spd_lim, acc_lim, turn_lim;
  logic [DIR_W-1:0] turn_dir;

  // Profile state
  mphase_t           mph;
  logic [TIME_W-1:0] t_start;
  longint            acc_dur, cru_dur, ramp_dur, ofs;

  result_t due_q[$];

  assign pending = due_q.size();

  function automatic longint eff_speed();
    return (spd_lim == 0) ? 64'sd1 : spd_lim;
  endfunction

  function automatic longint eff_accel();
    return (acc_lim == 0) ? 64'sd1 : acc_lim;
  endfunction

  function automatic result_t make_beat(longint spd, longint turn, logic [1:0] ph,
                                        logic done);
    result_t b;
    longint  s;
    s = spd;
    if (s < 0) s = 0;
    if (s > eff_speed()) s = eff_speed();
    b.speed_cmd     = s[SPD_W-1:0];
    b.turn_rate_cmd = turn[SPD_W-1:0];
    b.phase         = ph;
    b.done_res      = done;
    b.last_result   = 1'b0;
    return b;
  endfunction

  // Advance the profile by one accepted beat and queue what it should give
  task automatic profile_step(input item_t it);
    longint  vm, va, e, d, tc, o, r, w, sum_mm;
    result_t outs[$];
    vm = eff_speed();
    va = eff_accel();
    if (it.command == 1'b0) begin
      sum_mm  = l1_mm + lk_mm + l2_mm;
      t_start = it.time_stamp;
      acc_dur = vm * MICRO / va;
      if (acc_dur > T_UMAX) acc_dur = T_UMAX;
      ramp_dur = lk_mm * MICRO / vm;
      if (ramp_dur > T_UMAX) ramp_dur = T_UMAX;
      tc = (sum_mm * va - vm * vm) * MICRO / (vm * va);
      if (tc < 0) tc = 0;
      if (tc > T_UMAX) tc = T_UMAX;
      cru_dur = tc;
      ofs = (2 * l1_mm * va - vm * vm) * MICRO / (2 * vm * va);
      if (ofs > T_SMAX) ofs = T_SMAX;
      if (ofs < -T_SMAX - 1) ofs = -T_SMAX - 1;
      mph = MP_ACCEL;
      return;
    end
    e = {32'd0, it.time_stamp - t_start};
    case (mph)
      MP_ACCEL: begin
        outs.push_back(make_beat(va * e / MICRO, 0, PH_ACCEL, 1'b0));
        if (e >= acc_dur) begin
          outs.push_back(make_beat(vm, 0, PH_CRUISE, 1'b0));
          mph = MP_CRUISE;
        end
      end
      MP_CRUISE: begin
        o = ofs;
        r = ramp_dur;
        w = 0;
        d = e - acc_dur;
        if (d > o && d < o + r)
          w = (d - o) * turn_lim / r;
        else if (d > o + r && d < o + 2 * r)
          w = (2 * r - (d - o)) * turn_lim / r;
        if (turn_dir == DIR_STRAIGHT) w = 0;
        else if (turn_dir[1]) w = -w;
        outs.push_back(make_beat(vm, w, PH_CRUISE, 1'b0));
        if (d >= cru_dur) mph = MP_DECEL;
      end
      MP_DECEL: begin
        d = e - acc_dur - cru_dur;
        outs.push_back(make_beat(vm - va * d / MICRO, 0, PH_DECEL, 1'b0));
        if (d >= acc_dur) begin
          outs.push_back(make_beat(0, 0, PH_STOP, 1'b1));
          mph = MP_STOP;
        end
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size()-1].last_result = 1'b1;
    foreach (outs[k]) due_q.push_back(outs[k]);
  endtask

  // Register copy, prediction and comparison
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      l1_mm = 0; lk_mm = 0; l2_mm = 0;
      turn_dir = RST_TURN_DIR;
      spd_lim  = RST_MAX_SPEED;
      acc_lim  = RST_ACCEL;
      turn_lim = RST_MAX_TURN;
      mph = MP_IDLE;
      t_start = '0;
      acc_dur = 0; cru_dur = 0; ramp_dur = 0; ofs = 0;
      due_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIST_BEFORE: l1_mm    = cfg_data[DIST_W-1:0];
          CFG_CURVE_LEN:   lk_mm    = cfg_data[DIST_W-1:0];
          CFG_DIST_AFTER:  l2_mm    = cfg_data[DIST_W-1:0];
          CFG_TURN_DIR:    turn_dir = cfg_data[DIR_W-1:0];
          CFG_MAX_SPEED:   spd_lim  = cfg_data[SPD_W-1:0];
          CFG_PATH_ACCEL:  acc_lim  = cfg_data[SPD_W-1:0];
          CFG_MAX_TURN:    turn_lim = cfg_data[TURN_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) profile_step(item);
      if (result_valid && !result_stall) begin
        if (due_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected beat: %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = due_q.pop_front();
          if (result !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected %p, got %p", want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tsct_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                item;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int cycles;
  int sent;

  // Stimulus mood, shared with the receiver
  bit calm;
  bit hold_long;

  // Own copy of what was written, only to size the time steps
  longint w_l1, w_lk, w_l2, w_vm, w_va;

  trapezoid_speed_clothoid_turn_profile_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tsct_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[trapezoid_speed_clothoid_turn_profile_core] ERROR");
      $finish;
    end
  end

  // Receiver: random hold-off per beat, one long hold-off on request
  initial begin
    int n;
    result_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        n = 3000;
        hold_long = 1'b0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 18);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!(result_valid && !result_stall)) @(posedge clk);
    end
  end

  // One beat into the core, with a random gap ahead of it
  task automatic send_beat(input logic cmd, input logic [TIME_W-1:0] ts);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    item.command    <= cmd;
    item.time_stamp <= ts;
    @(posedge clk);
    while (!(item_valid && !item_stall)) @(posedge clk);
    sent++;
  endtask

  // Stop offering and wait until every expected beat is back and the core is quiet
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DIST_BEFORE: w_l1 = val[DIST_W-1:0];
      CFG_CURVE_LEN:   w_lk = val[DIST_W-1:0];
      CFG_DIST_AFTER:  w_l2 = val[DIST_W-1:0];
      CFG_MAX_SPEED:   w_vm = val[SPD_W-1:0];
      CFG_PATH_ACCEL:  w_va = val[SPD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_W-1:0] l1, lk, l2, dir, vm, va, wm);
    write_reg(CFG_DIST_BEFORE, l1);
    write_reg(CFG_CURVE_LEN, lk);
    write_reg(CFG_DIST_AFTER, l2);
    write_reg(CFG_TURN_DIR, dir);
    write_reg(CFG_MAX_SPEED, vm);
    write_reg(CFG_PATH_ACCEL, va);
    write_reg(CFG_MAX_TURN, wm);
  endtask

  // Start, then samples stepping through the whole profile, with some noise
  task automatic run_profile(input int nsamp);
    longint vm, va, span, stepmax;
    logic [TIME_W-1:0] t;
    int k, pick;
    vm = (w_vm == 0) ? 1 : w_vm;
    va = (w_va == 0) ? 1 : w_va;
    span = 2 * vm * 1000000 / va + (w_l1 + w_lk + w_l2) * 1000000 / vm + 1;
    stepmax = 2 * span / nsamp + 1;
    if (stepmax > 64'h7FFF_FFFF) stepmax = 64'h7FFF_FFFF;
    t = $urandom;
    send_beat(1'b0, t);
    for (k = 0; k < nsamp; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_beat(1'b1, $urandom);
      end else if (pick < 6) begin
        t = t + $urandom_range(0, 1000);
        send_beat(1'b0, t);
      end else begin
        t = t + 32'($urandom_range(1, int'(stepmax)));
        send_beat(1'b1, t);
      end
    end
  endtask

  initial begin
    int p, nsamp;
    logic [CFG_W-1:0] l1, lk, l2, vm, va;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_long  = 1'b0;
    sent       = 0;
    w_l1 = 0; w_lk = 0; w_l2 = 0; w_vm = 500; w_va = 500;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, sample while idle, wrap of the time stamp
    send_beat(1'b1, 32'd0);
    send_beat(1'b0, 32'hFFFF_FFF0);
    send_beat(1'b1, 32'hFFFF_FFF0);
    send_beat(1'b1, 32'hFFFF_FFF0 + 32'd500000);
    send_beat(1'b1, 32'hFFFF_FFF0 + 32'd1000000);
    send_beat(1'b1, 32'hFFFF_FFF0 + 32'd1000001);
    send_beat(1'b1, 32'hFFFF_FFF0 + 32'd1600000);
    send_beat(1'b1, 32'hFFFF_FFF0 + 32'd2500000);
    send_beat(1'b1, 32'hFFFF_FFF0 + 32'd2600000);
    // restart mid-profile
    send_beat(1'b0, 32'd100);
    send_beat(1'b1, 32'd200);
    send_beat(1'b0, 32'd300);
    send_beat(1'b1, 32'hFFFF_FFFF);
    drain();

    // Largest registers, right turn; unknown index must be ignored
    write_all(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h3, 20'hFFFF, 20'hFFFF, 20'h7FFF);
    cfg_we    <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data  <= 20'hFFFFF;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    send_beat(1'b0, 32'd0);
    send_beat(1'b1, 32'd0);
    send_beat(1'b1, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'h8000_0000);
    drain();

    // Zero speed and accel act as one; minus two direction; all zero distances
    write_all(20'd0, 20'd0, 20'd0, 20'h2, 20'd0, 20'd0, 20'd0);
    send_beat(1'b0, 32'd5);
    send_beat(1'b1, 32'd1000005);
    send_beat(1'b1, 32'd2000006);
    send_beat(1'b1, 32'd3000010);
    drain();

    // Random profiles
    p = 0;
    while (sent < 850) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        l1 = CFG_W'($urandom); lk = CFG_W'($urandom); l2 = CFG_W'($urandom);
        vm = CFG_W'($urandom); va = CFG_W'($urandom);
      end else begin
        vm = CFG_W'($urandom_range(50, 3000));
        va = CFG_W'($urandom_range(200, 20000));
        l1 = CFG_W'($urandom_range(0, 2000));
        lk = CFG_W'($urandom_range(0, 2000));
        l2 = CFG_W'($urandom_range(0, 2000));
      end
      write_all(l1, lk, l2, CFG_W'($urandom_range(0, 3)), vm, va, CFG_W'($urandom));
      nsamp = $urandom_range(15, 35);
      if (p == 3) begin
        calm = 1'b0;
        hold_long = 1'b1;
      end
      run_profile(nsamp);
      // sender pauses until every beat has come back
      drain();
      p++;
    end

    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[trapezoid_speed_clothoid_turn_profile_core] OK");
    end else begin
      $display("[trapezoid_speed_clothoid_turn_profile_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/tsct_pkg.sv
hdl/tsct_div.sv
hdl/tsct_datapath.sv
hdl/tsct_ctrl.sv
hdl/trapezoid_speed_clothoid_turn_profile_core.sv
sim/tsct_checker.sv
sim/tb_top.sv
